// ===== rtl/core/byte_histogram_checksum_assert.svh =====
// assertion macros used by the byte histogram port checker
`ifndef BYTE_HISTOGRAM_CHECKSUM_ASSERT_SVH
`define BYTE_HISTOGRAM_CHECKSUM_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define BHC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("byte histogram assertion failed");

// next-cycle implication, off while reset is asserted
`define BHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("byte histogram assertion failed");

// next-cycle implication that also runs through reset
`define BHC_ASSERT_ALWAYS(lbl, clk, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
		else $error("byte histogram assertion failed");

`endif

// ===== rtl/core/bhc_pkg.sv =====
// package: constants, action codes and shared types of the byte histogram
package bhc_pkg;

	localparam int NUM_BINS     = 256;
	localparam int COUNT_WIDTH  = 32;
	localparam int BIN_AW       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int ACTION_WIDTH = 2;
	localparam int VALUE_WIDTH  = 8;
	localparam int SUM_WIDTH    = 48;
	localparam int OUT_WIDTH    = 32;

	localparam logic [ACTION_WIDTH-1:0] ACT_COUNT = 2'd0;
	localparam logic [ACTION_WIDTH-1:0] ACT_READ  = 2'd1;
	localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR = 2'd2;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [ACTION_WIDTH-1:0] action;
		logic [VALUE_WIDTH-1:0]  value;
	} item_t;

	typedef struct packed {
		logic [OUT_WIDTH-1:0] bin_count;
		logic [SUM_WIDTH-1:0] check_sum;
		logic [OUT_WIDTH-1:0] byte_total;
	} result_t;

	// low output bits of a count of any supported width
	function automatic logic [OUT_WIDTH-1:0] out_low(input logic [COUNT_WIDTH-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[OUT_WIDTH-1:0];
	endfunction

endpackage

// ===== rtl/core/bhc_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
module bhc_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read-first: a read at the written address returns the old word
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/bhc_update.sv =====
// read-modify-write stage: bin increment with forwarding, checksum and total
module bhc_update import bhc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_s1,
	input  item_t                  item_s1,
	input  logic [COUNT_WIDTH-1:0] rd_data,
	output logic                   wr_en,
	output logic [BIN_AW-1:0]      wr_addr,
	output logic [COUNT_WIDTH-1:0] wr_data,
	output logic                   res_valid,
	output result_t                res
);

	logic                   fwd_valid_q;
	logic [BIN_AW-1:0]      fwd_addr_q;
	logic [COUNT_WIDTH-1:0] fwd_data_q;
	logic [SUM_WIDTH-1:0]   sum_q;
	logic [COUNT_WIDTH-1:0] total_q;

	logic [BIN_AW-1:0]      addr;
	logic                   in_range;
	logic [COUNT_WIDTH-1:0] cur;
	logic [COUNT_WIDTH-1:0] bin_next;
	logic [SUM_WIDTH-1:0]   sum_next;
	logic [COUNT_WIDTH-1:0] total_next;

	assign addr     = item_s1.value[BIN_AW-1:0];
	assign in_range = {1'b0, item_s1.value} < (VALUE_WIDTH+1)'(NUM_BINS);

	// the word written last cycle is not yet visible in the ram read
	assign cur      = (fwd_valid_q && fwd_addr_q == addr) ? fwd_data_q : rd_data;
	assign bin_next = (cur == COUNT_MAX) ? cur : cur + COUNT_WIDTH'(1);

	assign wr_en   = valid_s1 && item_s1.action == ACT_COUNT && in_range;
	assign wr_addr = addr;
	assign wr_data = bin_next;

	always_comb begin
		sum_next   = sum_q;
		total_next = total_q;
		case (item_s1.action)
			ACT_COUNT: begin
				sum_next   = sum_q + SUM_WIDTH'(item_s1.value) + SUM_WIDTH'(1);
				total_next = (total_q == COUNT_MAX) ? total_q : total_q + COUNT_WIDTH'(1);
			end
			ACT_CLEAR: begin
				sum_next   = '0;
				total_next = '0;
			end
			default: begin
				sum_next   = sum_q;
				total_next = total_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			total_q     <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= wr_en;
			if (valid_s1) begin
				sum_q   <= sum_next;
				total_q <= total_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
		end
	end

	assign res_valid      = valid_s1;
	assign res.bin_count  = (item_s1.action == ACT_READ && in_range) ? out_low(cur) : '0;
	assign res.check_sum  = sum_next;
	assign res.byte_total = out_low(total_next);

endmodule

// ===== rtl/core/bhc_out_fifo.sv =====
// two-entry result queue between the update stage and the output port
module bhc_out_fifo import bhc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  result_t    push_data,
	input  logic       pop,
	output logic       head_valid,
	output result_t    head,
	output logic [1:0] count
);

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign head_valid = cnt_q != 2'd0;
	assign head       = entry_q[rd_ptr_q];
	assign count      = cnt_q;

endmodule

// ===== rtl/core/byte_histogram_checksum.sv =====
// top level of the byte histogram with running checksum
//
//   channel | direction | payload                            | handshake
//   in      | sink      | action, byte_value, bin_index      | in_valid / in_ready
//   out     | source    | bin_count, check_sum, byte_total   | out_valid / out_ready
//
// one item per cycle while in_ready is high; a result is queued from the update stage
// the bin ram has one write and one read port; a bin hit twice in a row is forwarded
// reset and every clear walk all NUM_BINS bins with in_ready low
// a two-entry result queue holds results while out_ready is low; in_ready
// drops during a sweep and when the queue and the update stage have no room left
module byte_histogram_checksum import bhc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [ACTION_WIDTH-1:0] action,
	input  logic [VALUE_WIDTH-1:0]  byte_value,
	input  logic [VALUE_WIDTH-1:0]  bin_index,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [OUT_WIDTH-1:0]    bin_count,
	output logic [SUM_WIDTH-1:0]    check_sum,
	output logic [OUT_WIDTH-1:0]    byte_total
);

	logic                   valid_s1;
	item_t                  item_s1;
	logic                   clearing_q;
	logic [BIN_AW-1:0]      sweep_cnt_q;

	logic                   in_xfer;
	logic                   pop;
	logic [VALUE_WIDTH-1:0] rd_value;
	logic [COUNT_WIDTH-1:0] rd_data;
	logic                   upd_wr_en;
	logic [BIN_AW-1:0]      upd_wr_addr;
	logic [COUNT_WIDTH-1:0] upd_wr_data;
	logic                   res_valid;
	result_t                res;
	result_t                head;
	logic [1:0]             fifo_cnt;
	logic                   ram_we;
	logic [BIN_AW-1:0]      ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;

	assign pop      = out_valid && out_ready;
	// room for the item in the update stage plus this one, counting a pop now
	assign in_ready = !clearing_q &&
		(3'(fifo_cnt) + 3'(valid_s1) <= 3'd1 + 3'(pop));
	assign in_xfer  = in_valid && in_ready;

	assign rd_value = (action == ACT_READ) ? bin_index : byte_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			clearing_q  <= 1'b1;
			sweep_cnt_q <= '0;
		end else begin
			valid_s1 <= in_xfer;
			if (clearing_q) begin
				sweep_cnt_q <= sweep_cnt_q + BIN_AW'(1);
				if (sweep_cnt_q == BIN_AW'(NUM_BINS - 1)) begin
					clearing_q <= 1'b0;
				end
			end else if (in_xfer && action == ACT_CLEAR) begin
				clearing_q  <= 1'b1;
				sweep_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.action <= action;
			item_s1.value  <= rd_value;
		end
	end

	// the sweep owns the write port; no count is in flight while it runs
	assign ram_we    = clearing_q || upd_wr_en;
	assign ram_waddr = clearing_q ? sweep_cnt_q : upd_wr_addr;
	assign ram_wdata = clearing_q ? '0 : upd_wr_data;

	bhc_ram #(
		.DEPTH(NUM_BINS),
		.WIDTH(COUNT_WIDTH)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_value[BIN_AW-1:0]),
		.rdata(rd_data)
	);

	bhc_update u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.rd_data  (rd_data),
		.wr_en    (upd_wr_en),
		.wr_addr  (upd_wr_addr),
		.wr_data  (upd_wr_data),
		.res_valid(res_valid),
		.res      (res)
	);

	bhc_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (pop),
		.head_valid(out_valid),
		.head      (head),
		.count     (fifo_cnt)
	);

	assign bin_count  = head.bin_count;
	assign check_sum  = head.check_sum;
	assign byte_total = head.byte_total;

endmodule

// ===== rtl/core/bhc_port_checker.sv =====
// port-level checker for the byte histogram, bound to the top level
`include "byte_histogram_checksum_assert.svh"

module bhc_port_checker import bhc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [OUT_WIDTH-1:0] bin_count,
	input logic [SUM_WIDTH-1:0] check_sum,
	input logic [OUT_WIDTH-1:0] byte_total
);

	logic                             out_xfer;
	logic                             out_stall;
	logic [2*OUT_WIDTH+SUM_WIDTH-1:0] out_payload;
	logic [OUT_WIDTH-1:0]             total_prev_q;
	logic                             total_step_ok;

	assign out_xfer    = out_valid && out_ready;
	assign out_stall   = out_valid && !out_ready;
	assign out_payload = {bin_count, check_sum, byte_total};

	// total shown in the previous cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_prev_q <= '0;
		end else begin
			total_prev_q <= byte_total;
		end
	end

	assign total_step_ok = byte_total == total_prev_q ||
		byte_total == total_prev_q + OUT_WIDTH'(1) ||
		byte_total == '0;

	// a stalled result stays offered
	`BHC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid)

	// a stalled result keeps its payload
	`BHC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_stall, $stable(out_payload))

	// between back-to-back result transfers the total holds, steps by one or clears
	`BHC_ASSERT_NEXT(a_total_step, clk, arst_n, out_xfer, !out_xfer || total_step_ok)

	// both sides are quiet once reset is seen, as the bin sweep begins
	`BHC_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n, !in_ready && !out_valid)

endmodule

bind byte_histogram_checksum bhc_port_checker u_port_checker (.*);
